### hw/rtl/bfid_pkg.sv
package bfid_pkg;

	localparam int NLANE = 9;
	localparam int RECIP_SHIFT = 23;
	localparam logic [7:0] PAD_BYTE = 8'd255;

	typedef enum logic [2:0] {
		MODE_MONO8    = 3'd0,
		MODE_RGB8     = 3'd1,
		MODE_XBGR8    = 3'd2,
		MODE_BGR8     = 3'd3,
		MODE_CMYK8    = 3'd4,
		MODE_DEVICEN8 = 3'd5,
		MODE_MONO1    = 3'd6,
		MODE_RSVD     = 3'd7
	} color_mode_t;

	typedef enum logic [2:0] {
		REG_COLOR_MODE = 3'd0,
		REG_ALPHA_EN   = 3'd1,
		REG_SRC_W      = 3'd2,
		REG_SRC_H      = 3'd3,
		REG_TGT_W      = 3'd4,
		REG_TGT_H      = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_RUN  = 2'd0,
		ST_DIV  = 2'd1
	} ctl_state_t;

	typedef struct packed {
		logic [7:0] comp0;
		logic [7:0] comp1;
		logic [7:0] comp2;
		logic [7:0] comp3;
		logic [7:0] comp4;
		logic [7:0] comp5;
		logic [7:0] comp6;
		logic [7:0] comp7;
		logic [7:0] alpha_in;
	} pix_in_t;

	typedef struct packed {
		logic [7:0] out_byte0;
		logic [7:0] out_byte1;
		logic [7:0] out_byte2;
		logic [7:0] out_byte3;
		logic [7:0] out_byte4;
		logic [7:0] out_byte5;
		logic [7:0] out_byte6;
		logic [7:0] out_byte7;
		logic [7:0] out_alpha;
		logic [3:0] byte_count;
		logic       row_end;
		logic       image_end;
	} pix_out_t;

	// control carried from the sequencer to the lanes for one source pixel
	typedef struct packed {
		logic        restart_run;
		logic        box_done;
		logic        first_row;
		logic        last_row;
		logic        alpha_en;
		logic        row_end;
		logic        image_end;
		logic [23:0] recip;
	} lane_ctl_t;

endpackage

### hw/rtl/bfid_if.sv
interface bfid_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/box_filter_image_downscaler.sv
// Box-filter image downscaler.
// Channels: src (sink, one source pixel per item, raster order, eight
// component bytes and alpha) and dst (source, one destination pixel per item).
// Configuration: APB-style write port, register i at byte address 4*i.
// A write restarts the image at its first pixel; src is then held while a
// serial divider splits the source sizes by the target sizes.
// Throughput: one source pixel a cycle while no result is pending. At the
// first pixel of each row group src is held while the shared serial divider
// forms the two reciprocals, one after the other. A pixel that closes a box
// in the last row of a group holds src off until its result is taken.
// Result path: the column memory read is registered into s2, the sum and
// multiply into s3, and the colour-mode merge into the register that drives dst.
// Nine lanes (8 components + alpha) each hold a run sum and a column-sum
// memory; the merging stage reorders the averages by colour mode.
// Reset clears all control state; the column memories need no clearing
// since the first row of every group ignores the stored sums.
// When dst stalls, src is held off as soon as any result is in flight or
// waiting, so no result is lost.
module box_filter_image_downscaler
	import bfid_pkg::*;
#(
	parameter int MAX_TARGET_WIDTH = 4096,
	parameter int MAX_SOURCE_WIDTH = 8192,
	parameter int MAX_COMPONENTS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	bfid_if.sink        src,
	bfid_if.source      dst,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int CW = $clog2(MAX_TARGET_WIDTH);
	localparam int NDEV = (MAX_COMPONENTS < 8) ? MAX_COMPONENTS : 8;
	localparam int LIM = (MAX_SOURCE_WIDTH < MAX_TARGET_WIDTH) ? MAX_SOURCE_WIDTH
		: MAX_TARGET_WIDTH;

	// configuration
	logic [2:0]  mode_q;
	logic        alpha_q;
	logic [13:0] sw_q;
	logic [15:0] sh_q;
	logic [12:0] tw_q;
	logic [15:0] th_q;
	logic        wr;
	logic [2:0]  ridx;

	assign pready = 1'b1;
	assign ridx   = paddr[4:2];
	assign wr     = psel && penable && pwrite && (paddr[1:0] == 2'b00) && paddr[4:2] <= 3'd5;

	always_comb begin
		case (reg_idx_t'(ridx))
			REG_COLOR_MODE: prdata = {29'd0, mode_q};
			REG_ALPHA_EN:   prdata = {31'd0, alpha_q};
			REG_SRC_W:      prdata = {18'd0, sw_q};
			REG_SRC_H:      prdata = {16'd0, sh_q};
			REG_TGT_W:      prdata = {19'd0, tw_q};
			REG_TGT_H:      prdata = {16'd0, th_q};
			default:        prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= '0; alpha_q <= 1'b0;
			sw_q <= 14'd1; sh_q <= 16'd1; tw_q <= 13'd1; th_q <= 16'd1;
		end else if (wr) begin
			case (reg_idx_t'(ridx))
				REG_COLOR_MODE: mode_q  <= pwdata[2:0];
				REG_ALPHA_EN:   alpha_q <= pwdata[0];
				REG_SRC_W:      sw_q    <= pwdata[13:0];
				REG_SRC_H:      sh_q    <= pwdata[15:0];
				REG_TGT_W:      tw_q    <= pwdata[12:0];
				REG_TGT_H:      th_q    <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// effective sizes (widened to 17 bits)
	logic [16:0] esw, esh, etw, eth, lim;
	always_comb begin
		esw = (sw_q == 14'd0) ? 17'd1 : {3'd0, sw_q};
		if (esw > 17'(MAX_SOURCE_WIDTH)) esw = 17'(MAX_SOURCE_WIDTH);
		esh = (sh_q == 16'd0) ? 17'd1 : {1'b0, sh_q};
		lim = (esw < 17'(LIM)) ? esw : 17'(LIM);
		etw = (tw_q == 13'd0) ? 17'd1 : {4'd0, tw_q};
		if (etw > lim) etw = lim;
		eth = (th_q == 16'd0) ? 17'd1 : {1'b0, th_q};
		if (eth > esh) eth = esh;
	end

	// quotients are found by a serial divider after reset and after every config write
	// (sizes only change on a config write, which restarts the image)
	logic [16:0] xp_q, xq_q, yp_q, yq_q;
	logic        sz_ok_q;
	logic [4:0]  sz_cnt_q;
	logic [16:0] dv_num_q, dv_rem_q, dv_quo_q;
	logic        sz_phase_q;
	logic [17:0] sz_trial;
	logic [16:0] sz_den;

	assign sz_den   = sz_phase_q ? eth : etw;
	assign sz_trial = {dv_rem_q, dv_num_q[16]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sz_ok_q <= 1'b0; sz_cnt_q <= '0; sz_phase_q <= 1'b0;
		end else if (wr) begin
			sz_ok_q <= 1'b0; sz_cnt_q <= '0; sz_phase_q <= 1'b0;
		end else if (!sz_ok_q) begin
			sz_cnt_q <= (sz_cnt_q == 5'd18) ? 5'd0 : sz_cnt_q + 5'd1;
			if (sz_cnt_q == 5'd18) begin
				if (sz_phase_q) sz_ok_q <= 1'b1;
				sz_phase_q <= ~sz_phase_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!sz_ok_q) begin
			if (sz_cnt_q == 5'd0) begin
				dv_num_q <= sz_phase_q ? esh : esw;
				dv_rem_q <= '0;
				dv_quo_q <= '0;
			end else if (sz_cnt_q == 5'd18) begin
				if (sz_phase_q) begin yp_q <= dv_quo_q; yq_q <= dv_rem_q; end
				else begin xp_q <= dv_quo_q; xq_q <= dv_rem_q; end
			end else begin
				dv_num_q <= {dv_num_q[15:0], 1'b0};
				if (sz_trial >= {1'b0, sz_den}) begin
					dv_rem_q <= 17'(sz_trial - {1'b0, sz_den});
					dv_quo_q <= {dv_quo_q[15:0], 1'b1};
				end else begin
					dv_rem_q <= sz_trial[16:0];
					dv_quo_q <= {dv_quo_q[15:0], 1'b0};
				end
			end
		end
	end

	// sequencer state
	logic [16:0] scol_q, rig_q, tcol_q, trow_q, cerr_q, rerr_q, csl_q, rgs_q;
	logic [23:0] rs_q, rl_q;
	logic        st_new_q;   // reciprocals pending for current group start
	ctl_state_t  state_q, state_d;
	logic        div_start, div_done;
	logic [23:0] div_quo;
	logic        div_which_q;
	logic [32:0] div_den;
	logic [16:0] ystep;
	logic [16:0] yt_calc;

	// group start row step
	always_comb begin
		yt_calc = 17'(rerr_q + yq_q);
		ystep   = yp_q;
		if (yt_calc >= eth) begin
			yt_calc = 17'(yt_calc - eth);
			ystep   = 17'(yp_q + 17'd1);
		end
	end

	logic group_start;
	assign group_start = (scol_q == 17'd0) && (rig_q == 17'd0);

	// pipeline occupancy for back-pressure
	logic [1:0] inflight;
	logic       out_v_q;
	logic       accept;
	logic       run_ok;

	assign run_ok = sz_ok_q && (state_q == ST_RUN) && !(group_start && st_new_q);
	assign src.ready = run_ok && !out_v_q && (inflight == 2'd0) && !wr;
	assign accept = src.valid && src.ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_RUN: if (sz_ok_q && group_start && st_new_q && !wr) state_d = ST_DIV;
			ST_DIV: if (div_done && div_which_q) state_d = ST_RUN;
			default: state_d = ST_RUN;
		endcase
		if (wr) state_d = ST_RUN;
	end

	always_comb begin
		div_start = 1'b0;
		case (state_q)
			ST_RUN: div_start = (state_d == ST_DIV);
			ST_DIV: div_start = div_done && !div_which_q;
			default: div_start = 1'b0;
		endcase
	end

	// short box divisor starts from the run state, long box divisor from the divide state
	logic [32:0] xpl;
	assign xpl = (state_q == ST_DIV) ? 33'(xp_q + 17'd1) : {16'd0, xp_q};
	assign div_den = 33'(((state_q == ST_RUN) ? ystep : rgs_q) * xpl);

	bfid_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.divisor(div_den), .done(div_done), .quotient(div_quo)
	);

	// lane control for this pixel
	logic [16:0] csl_eff, cerr_eff, tcol_eff, xt;
	logic        long_eff;
	logic        long_q;
	logic        restart_run;
	always_comb begin
		csl_eff  = (scol_q == 17'd0) ? 17'd0 : csl_q;
		cerr_eff = (scol_q == 17'd0) ? 17'd0 : cerr_q;
		tcol_eff = (scol_q == 17'd0) ? 17'd0 : tcol_q;
		long_eff = long_q;
		restart_run = (csl_eff == 17'd0);
		xt = 17'(cerr_eff + xq_q);
		if (restart_run) begin
			if (xt >= etw) begin
				xt = 17'(xt - etw); csl_eff = 17'(xp_q + 17'd1); long_eff = 1'b1;
			end else begin
				csl_eff = xp_q; long_eff = 1'b0;
			end
			cerr_eff = xt;
		end
	end

	logic [16:0] csl_nxt, scol_nxt;
	logic        box_done, col_ok, last_row, rend, iend;
	assign csl_nxt  = 17'(csl_eff - 17'd1);
	assign scol_nxt = 17'(scol_q + 17'd1);
	assign box_done = (csl_nxt == 17'd0);
	assign col_ok   = tcol_eff < 17'(MAX_TARGET_WIDTH);
	assign last_row = 17'(rig_q + 17'd1) >= rgs_q;
	assign rend     = 17'(tcol_eff + 17'd1) >= etw;
	assign iend     = rend && (17'(trow_q + 17'd1) >= eth);

	lane_ctl_t lctl;
	always_comb begin
		lctl.restart_run = restart_run;
		lctl.box_done    = box_done;
		lctl.first_row   = (rig_q == 17'd0);
		lctl.last_row    = last_row;
		lctl.alpha_en    = alpha_q;
		lctl.row_end     = rend;
		lctl.image_end   = iend;
		lctl.recip       = long_eff ? rl_q : rs_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN; st_new_q <= 1'b1; div_which_q <= 1'b0;
			scol_q <= '0; rig_q <= '0; tcol_q <= '0; trow_q <= '0;
			cerr_q <= '0; rerr_q <= '0; csl_q <= '0; rgs_q <= '0; long_q <= 1'b0;
			rs_q <= '0; rl_q <= '0;
		end else if (wr) begin
			state_q <= ST_RUN; st_new_q <= 1'b1; div_which_q <= 1'b0;
			scol_q <= '0; rig_q <= '0; tcol_q <= '0; trow_q <= '0;
			cerr_q <= '0; rerr_q <= '0; csl_q <= '0; rgs_q <= '0; long_q <= 1'b0;
			rs_q <= '0; rl_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_RUN && state_d == ST_DIV) begin
				rerr_q <= yt_calc;
				rgs_q  <= ystep;
				div_which_q <= 1'b0;
			end
			if (state_q == ST_DIV && div_done) begin
				if (div_which_q) begin
					rl_q <= div_quo; st_new_q <= 1'b0;
				end else begin
					rs_q <= div_quo;
				end
				div_which_q <= ~div_which_q;
			end
			if (accept) begin
				csl_q  <= csl_nxt;
				cerr_q <= cerr_eff;
				long_q <= long_eff;
				tcol_q <= (box_done && col_ok) ? 17'(tcol_eff + 17'd1) : tcol_eff;
				if (scol_nxt >= esw) begin
					scol_q <= '0;
					if (17'(rig_q + 17'd1) >= rgs_q) begin
						rig_q <= '0;
						st_new_q <= 1'b1;
						if (17'(trow_q + 17'd1) >= eth) begin
							trow_q <= '0; rerr_q <= '0;
						end else begin
							trow_q <= 17'(trow_q + 17'd1);
						end
					end else begin
						rig_q <= 17'(rig_q + 17'd1);
					end
				end else begin
					scol_q <= scol_nxt;
				end
			end
		end
	end

	// lanes
	logic [7:0] pix [NLANE];
	logic [7:0] avg [NLANE];
	assign pix[0] = src.data.comp0;
	assign pix[1] = src.data.comp1;
	assign pix[2] = src.data.comp2;
	assign pix[3] = src.data.comp3;
	assign pix[4] = src.data.comp4;
	assign pix[5] = src.data.comp5;
	assign pix[6] = src.data.comp6;
	assign pix[7] = src.data.comp7;
	assign pix[8] = src.data.alpha_in;

	for (genvar g = 0; g < NLANE; g++) begin : g_lane
		bfid_lane #(.MAX_TARGET_WIDTH(MAX_TARGET_WIDTH), .CW(CW)) u_lane (
			.clk(clk), .in_go(accept),
			.add_en((g < 8) ? 1'b1 : alpha_q),
			.pix(pix[g]), .ctl(lctl), .col(tcol_eff[CW-1:0]), .col_ok(col_ok),
			.avg_s3(avg[g])
		);
	end

	// result side control: s2 then s3
	logic       v_s2, v_s3;
	logic       re_s2, ie_s2, re_s3, ie_s3;
	logic [2:0] mode_s3;
	logic       al_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0; v_s3 <= 1'b0;
		end else begin
			v_s2 <= accept && box_done && col_ok && last_row;
			v_s3 <= v_s2;
		end
	end
	always_ff @(posedge clk) begin
		if (accept) begin re_s2 <= rend; ie_s2 <= iend; end
		re_s3 <= re_s2; ie_s3 <= ie_s2; mode_s3 <= mode_q; al_s3 <= alpha_q;
	end
	assign inflight = {1'b0, v_s2} + {1'b0, v_s3};

	// merge: reorder by colour mode
	pix_out_t mrg, out_q;
	always_comb begin
		mrg = '0;
		case (color_mode_t'(mode_s3))
			MODE_MONO8: begin mrg.out_byte0 = avg[0]; mrg.byte_count = 4'd1; end
			MODE_RGB8: begin
				mrg.out_byte0 = avg[0]; mrg.out_byte1 = avg[1]; mrg.out_byte2 = avg[2];
				mrg.byte_count = 4'd3;
			end
			MODE_XBGR8: begin
				mrg.out_byte0 = avg[2]; mrg.out_byte1 = avg[1]; mrg.out_byte2 = avg[0];
				mrg.out_byte3 = PAD_BYTE; mrg.byte_count = 4'd4;
			end
			MODE_BGR8: begin
				mrg.out_byte0 = avg[2]; mrg.out_byte1 = avg[1]; mrg.out_byte2 = avg[0];
				mrg.byte_count = 4'd3;
			end
			MODE_CMYK8: begin
				mrg.out_byte0 = avg[0]; mrg.out_byte1 = avg[1];
				mrg.out_byte2 = avg[2]; mrg.out_byte3 = avg[3]; mrg.byte_count = 4'd4;
			end
			MODE_DEVICEN8: begin
				mrg.out_byte0 = avg[0]; mrg.out_byte1 = avg[1];
				mrg.out_byte2 = avg[2]; mrg.out_byte3 = avg[3];
				if (NDEV > 4) mrg.out_byte4 = avg[4];
				if (NDEV > 5) mrg.out_byte5 = avg[5];
				if (NDEV > 6) mrg.out_byte6 = avg[6];
				if (NDEV > 7) mrg.out_byte7 = avg[7];
				mrg.byte_count = 4'(NDEV);
			end
			default: mrg.byte_count = 4'd0;
		endcase
		mrg.out_alpha = al_s3 ? avg[8] : 8'd0;
		mrg.row_end   = re_s3;
		mrg.image_end = ie_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (v_s3) out_v_q <= 1'b1;
		else if (dst.ready) out_v_q <= 1'b0;
	end
	always_ff @(posedge clk) if (v_s3) out_q <= mrg;

	assign dst.valid = out_v_q;
	assign dst.data  = out_q;
endmodule

### hw/rtl/bfid_div.sv
// Restoring divider: 2^23 / divisor, one quotient bit a cycle.
module bfid_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [32:0] divisor,
	output logic        done,
	output logic [23:0] quotient
);
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic [33:0] rem_q;
	logic [23:0] quo_q;
	logic [32:0] div_q;
	logic [33:0] trial;
	logic        bit_in;

	assign bit_in = (cnt_q == 5'd23);
	assign trial  = {rem_q[32:0], bit_in};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 5'd23;
		end else if (busy_q) begin
			if (cnt_q == 5'd0) busy_q <= 1'b0;
			else cnt_q <= cnt_q - 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			if (trial >= {1'b0, div_q}) begin
				rem_q <= trial - {1'b0, div_q};
				quo_q <= {quo_q[22:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[22:0], 1'b0};
			end
		end
	end

	assign done     = busy_q && (cnt_q == 5'd0);
	assign quotient = (trial >= {1'b0, div_q}) ? {quo_q[22:0], 1'b1} : {quo_q[22:0], 1'b0};
endmodule

### hw/rtl/bfid_lane.sv
// One component: run sum, column sum and scale.
module bfid_lane
	import bfid_pkg::*;
#(
	parameter int MAX_TARGET_WIDTH = 4096,
	parameter int CW = $clog2(MAX_TARGET_WIDTH)
) (
	input  logic          clk,
	input  logic          in_go,
	input  logic          add_en,
	input  logic [7:0]    pix,
	input  lane_ctl_t     ctl,
	input  logic [CW-1:0] col,
	input  logic          col_ok,
	output logic [7:0]    avg_s3
);
	logic [31:0] mem [MAX_TARGET_WIDTH];
	logic [31:0] run_q;
	logic [31:0] run_new;
	logic [31:0] rd_s2, run_s2;
	logic        first_s2, last_s2, go_s2;
	logic [CW-1:0] col_s2;
	logic [23:0] recip_s2;
	logic [31:0] tot;
	logic [55:0] prod;
	logic        fwd;

	assign run_new = (ctl.restart_run ? 32'd0 : run_q) + (add_en ? {24'd0, pix} : 32'd0);
	// the column being written this edge is read back by the next pixel
	assign fwd     = go_s2 && !last_s2 && (col_s2 == col);

	always_ff @(posedge clk) begin
		if (in_go) begin
			run_q    <= run_new;
			rd_s2    <= fwd ? tot : mem[col];
			run_s2   <= run_new;
			first_s2 <= ctl.first_row;
			last_s2  <= ctl.last_row;
			col_s2   <= col;
			recip_s2 <= ctl.recip;
		end
		go_s2 <= in_go && ctl.box_done && col_ok;
		if (go_s2 && !last_s2) mem[col_s2] <= tot;
		if (go_s2 && last_s2) avg_s3 <= prod[30:23];
	end

	assign tot   = (first_s2 ? 32'd0 : rd_s2) + run_s2;
	assign prod  = {24'd0, tot} * {32'd0, recip_s2};
endmodule

### hw/rtl/bfid_checker.sv
module bfid_checker
	import bfid_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     src_valid,
	input logic     src_ready,
	input logic     dst_valid,
	input logic     dst_ready,
	input pix_out_t dst_data
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && !dst_ready |=> dst_valid && $stable(dst_data))
		else $error("dst item dropped or changed under stall");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid |-> dst_data.byte_count <= 4'd8)
		else $error("byte count out of range");
	a_iend: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_data.image_end |-> dst_data.row_end)
		else $error("image end without row end");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && !dst_ready |-> !src_ready)
		else $error("source taken while result waits");
endmodule

bind box_filter_image_downscaler bfid_checker u_chk (
	.clk(clk), .arst_n(arst_n), .src_valid(src.valid), .src_ready(src.ready),
	.dst_valid(dst.valid), .dst_ready(dst.ready), .dst_data(dst.data)
);

### bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top
	import bfid_pkg::*;
();

	localparam int CLK_HALF = 10;
	// cycles with no handshake of any kind before the run is declared hung;
	// covers the reciprocal divider pause plus a long stall on the result side
	localparam int STALL_LIMIT = 4000;
	// let the multiply stage drain before a register write
	localparam int DRAIN_CYCLES = 10;
	localparam int RANDOM_ITEMS = 950;

	// Scoreboard: tracks the downscaler's state, works out the destination
	// pixel caused by each accepted source pixel and checks the results.
	class DownscaleScoreboard;
		pix_out_t   pending[$];
		int         errors;
		logic [2:0] mode;
		logic       alpha_on;
		logic [13:0] src_w_reg;
		logic [15:0] src_h_reg;
		logic [12:0] dst_w_reg;
		logic [15:0] dst_h_reg;
		int unsigned eff_sw, eff_sh, eff_tw, eff_th;
		logic [31:0] col_sum [0:4096*NLANE-1];
		logic [31:0] run_sum [0:NLANE-1];
		int unsigned src_col, row_in_grp, tgt_col, tgt_row;
		int unsigned col_err, row_err, col_left, grp_rows;
		logic [23:0] recip_short, recip_long;
		logic        long_box;

		function new();
			errors = 0;
			mode = MODE_MONO8;
			alpha_on = 0;
			src_w_reg = 1; src_h_reg = 1; dst_w_reg = 1; dst_h_reg = 1;
			resize();
			restart();
		endfunction

		task report(string msg);
			$display("ERROR @%0t: %s", $time, msg);
			errors++;
		endtask

		function void resize();
			int unsigned lim;
			eff_sw = (src_w_reg == 0) ? 1 : src_w_reg;
			if (eff_sw > 8192) eff_sw = 8192;
			eff_sh = (src_h_reg == 0) ? 1 : src_h_reg;
			lim = (eff_sw < 4096) ? eff_sw : 4096;
			eff_tw = (dst_w_reg == 0) ? 1 : dst_w_reg;
			if (eff_tw > lim) eff_tw = lim;
			eff_th = (dst_h_reg == 0) ? 1 : dst_h_reg;
			if (eff_th > eff_sh) eff_th = eff_sh;
		endfunction

		function void restart();
			src_col = 0; row_in_grp = 0; tgt_col = 0; tgt_row = 0;
			col_err = 0; row_err = 0; col_left = 0; grp_rows = 0;
			recip_short = 0; recip_long = 0; long_box = 0;
			for (int i = 0; i < NLANE; i++) run_sum[i] = 0;
		endfunction

		function void write_reg(reg_idx_t idx, logic [31:0] v);
			case (idx)
				REG_COLOR_MODE: mode = v[2:0];
				REG_ALPHA_EN:   alpha_on = v[0];
				REG_SRC_W:      src_w_reg = v[13:0];
				REG_SRC_H:      src_h_reg = v[15:0];
				REG_TGT_W:      dst_w_reg = v[12:0];
				REG_TGT_H:      dst_h_reg = v[15:0];
				default: return;
			endcase
			resize();
			restart();
		endfunction

		function logic [7:0] scale(logic [31:0] s, logic [23:0] d);
			logic [63:0] prod;
			prod = {32'd0, s} * {40'd0, d};
			return prod[30:23];
		endfunction

		// note an accepted source pixel and queue the destination pixel it closes
		function void note_pixel(pix_in_t p);
			int unsigned yp, yq, xp, xq, yt, xt, ystep, base;
			logic [7:0]  lane [0:NLANE-1];
			logic [7:0]  avg [0:NLANE-1];
			logic [31:0] tot;
			logic        first_row, last_row, rend;
			pix_out_t    e;
			yp = eff_sh / eff_th; yq = eff_sh % eff_th;
			xp = eff_sw / eff_tw; xq = eff_sw % eff_tw;
			lane = '{p.comp0, p.comp1, p.comp2, p.comp3, p.comp4, p.comp5,
				p.comp6, p.comp7, p.alpha_in};
			if (src_col == 0 && row_in_grp == 0) begin
				yt = row_err + yq;
				ystep = yp;
				if (yt >= eff_th) begin
					yt -= eff_th;
					ystep = yp + 1;
				end
				row_err = yt;
				grp_rows = ystep;
				recip_short = 24'(64'd8388608 / (64'(ystep) * 64'(xp)));
				recip_long = 24'(64'd8388608 / (64'(ystep) * 64'(xp + 1)));
			end
			if (src_col == 0) begin
				col_err = 0; tgt_col = 0; col_left = 0;
			end
			if (col_left == 0) begin
				xt = col_err + xq;
				if (xt >= eff_tw) begin
					xt -= eff_tw;
					col_left = xp + 1;
					long_box = 1;
				end else begin
					col_left = xp;
					long_box = 0;
				end
				col_err = xt;
				for (int i = 0; i < NLANE; i++) run_sum[i] = 0;
			end
			for (int i = 0; i < 8; i++) run_sum[i] += lane[i];
			if (alpha_on) run_sum[8] += lane[8];
			col_left--;
			src_col++;

			if (col_left == 0 && tgt_col < 4096) begin
				base = tgt_col * NLANE;
				first_row = (row_in_grp == 0);
				last_row = (row_in_grp + 1 >= grp_rows);
				for (int i = 0; i < NLANE; i++) begin
					tot = (first_row ? 32'd0 : col_sum[base + i]) + run_sum[i];
					if (!last_row) col_sum[base + i] = tot;
					else avg[i] = scale(tot, long_box ? recip_long : recip_short);
				end
				if (last_row) begin
					e = '0;
					case (color_mode_t'(mode))
						MODE_MONO8: begin
							e.out_byte0 = avg[0]; e.byte_count = 1;
						end
						MODE_RGB8: begin
							e.out_byte0 = avg[0]; e.out_byte1 = avg[1];
							e.out_byte2 = avg[2]; e.byte_count = 3;
						end
						MODE_XBGR8: begin
							e.out_byte0 = avg[2]; e.out_byte1 = avg[1];
							e.out_byte2 = avg[0]; e.out_byte3 = PAD_BYTE;
							e.byte_count = 4;
						end
						MODE_BGR8: begin
							e.out_byte0 = avg[2]; e.out_byte1 = avg[1];
							e.out_byte2 = avg[0]; e.byte_count = 3;
						end
						MODE_CMYK8: begin
							e.out_byte0 = avg[0]; e.out_byte1 = avg[1];
							e.out_byte2 = avg[2]; e.out_byte3 = avg[3];
							e.byte_count = 4;
						end
						MODE_DEVICEN8: begin
							e.out_byte0 = avg[0]; e.out_byte1 = avg[1];
							e.out_byte2 = avg[2]; e.out_byte3 = avg[3];
							e.out_byte4 = avg[4]; e.out_byte5 = avg[5];
							e.out_byte6 = avg[6]; e.out_byte7 = avg[7];
							e.byte_count = 8;
						end
						default: e.byte_count = 0;
					endcase
					e.out_alpha = alpha_on ? avg[8] : 8'd0;
					rend = (tgt_col + 1 >= eff_tw);
					e.row_end = rend;
					e.image_end = rend && (tgt_row + 1 >= eff_th);
					pending.push_back(e);
				end
				tgt_col++;
			end

			if (src_col >= eff_sw) begin
				src_col = 0;
				row_in_grp++;
				if (row_in_grp >= grp_rows) begin
					row_in_grp = 0;
					tgt_row++;
					if (tgt_row >= eff_th) begin
						tgt_row = 0;
						row_err = 0;
					end
				end
			end
		endfunction

		task field(string name, int got, int want);
			if (got != want)
				report($sformatf("%s: got %0d, expected %0d", name, got, want));
		endtask

		task check_pixel(pix_out_t g);
			pix_out_t w;
			if (pending.size() == 0) begin
				report("destination pixel with none expected");
				return;
			end
			w = pending.pop_front();
			field("out_byte0", g.out_byte0, w.out_byte0);
			field("out_byte1", g.out_byte1, w.out_byte1);
			field("out_byte2", g.out_byte2, w.out_byte2);
			field("out_byte3", g.out_byte3, w.out_byte3);
			field("out_byte4", g.out_byte4, w.out_byte4);
			field("out_byte5", g.out_byte5, w.out_byte5);
			field("out_byte6", g.out_byte6, w.out_byte6);
			field("out_byte7", g.out_byte7, w.out_byte7);
			field("out_alpha", g.out_alpha, w.out_alpha);
			field("byte_count", g.byte_count, w.byte_count);
			field("row_end", g.row_end, w.row_end);
			field("image_end", g.image_end, w.image_end);
		endtask
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        psel = 0;
	logic        penable = 0;
	logic        pwrite = 0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	bfid_if #(.T(pix_in_t))  src_ch ();
	bfid_if #(.T(pix_out_t)) dst_ch ();

	DownscaleScoreboard sb = new();

	int src_idle_pct = 30;
	int dst_idle_pct = 73;
	int items_sent = 0;
	int quiet_cycles = 0;

	box_filter_image_downscaler uut (
		.clk(clk),
		.arst_n(arst_n),
		.src(src_ch),
		.dst(dst_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #(CLK_HALF) clk = ~clk;

	initial begin
		src_ch.valid = 0;
		src_ch.data = '0;
		dst_ch.ready = 0;
	end

	// randomly hold off the result side
	always @(negedge clk) begin
		dst_ch.ready <= ($urandom_range(99) >= dst_idle_pct);
	end

	// check each destination pixel as it is taken
	always @(posedge clk) begin
		if (arst_n && dst_ch.valid && dst_ch.ready)
			sb.check_pixel(dst_ch.data);
	end

	// watchdog: count cycles in which no item moves on any port
	always @(posedge clk) begin
		if (!arst_n || (src_ch.valid && src_ch.ready) || (dst_ch.valid && dst_ch.ready)
				|| (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// one APB write; leave psel high so back-to-back writes need no extra step
	task reg_write(reg_idx_t idx, logic [31:0] v);
		@(negedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= 5'(idx) << 2;
		pwdata <= v;
		@(negedge clk);
		penable <= 1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.write_reg(idx, v);
	endtask

	// drain the block, then program a whole setting
	task load_setting(int m, int a, int sw, int sh, int tw, int th);
		@(negedge clk);
		src_ch.valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		reg_write(REG_COLOR_MODE, m);
		reg_write(REG_ALPHA_EN, a);
		reg_write(REG_SRC_W, sw);
		reg_write(REG_SRC_H, sh);
		reg_write(REG_TGT_W, tw);
		reg_write(REG_TGT_H, th);
		@(negedge clk);
		psel <= 0;
		penable <= 0;
	endtask

	// offer one source pixel; valid stays high into the next call
	task send_pixel(pix_in_t p);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			src_ch.valid <= 0;
			@(negedge clk);
		end
		src_ch.valid <= 1;
		src_ch.data <= p;
		@(posedge clk);
		while (!src_ch.ready) @(posedge clk);
		sb.note_pixel(p);
		items_sent++;
	endtask

	function pix_in_t rand_pixel();
		pix_in_t p;
		case ($urandom_range(7))
			0: p = '0;
			1: p = '1;
			default: p = 72'({$urandom, $urandom, $urandom});
		endcase
		return p;
	endfunction

	initial begin
		int sw, sh, tw, th, count;
		repeat (6) @(negedge clk);
		arst_n = 1;

		// every colour mode, reserved one included, on a two-pixel box: extremes for even modes, AA/55 for odd
		for (int m = 0; m < 8; m++) begin
			load_setting(m, m % 2, 2, 1, 1, 1);
			send_pixel((m % 2) ? {9{8'hAA}} : '1);
			send_pixel((m % 2) ? {9{8'h55}} : '0);
		end
		// zero sizes count as one
		load_setting(MODE_RGB8, 1, 0, 0, 0, 0);
		send_pixel('1);
		// target larger than source is clamped
		load_setting(MODE_XBGR8, 0, 3, 2, 9, 9);
		repeat (6) send_pixel(rand_pixel());
		// oversized source width saturates, target width clamps to its maximum
		load_setting(MODE_DEVICEN8, 1, 16383, 65535, 8191, 65535);
		repeat (200) send_pixel(rand_pixel());

		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			// swap idling between sides, then run with none
			if (items_sent < RANDOM_ITEMS / 3) begin
				src_idle_pct = 30; dst_idle_pct = 73;
			end else if (items_sent < 2 * RANDOM_ITEMS / 3) begin
				src_idle_pct = 73; dst_idle_pct = 30;
			end else begin
				src_idle_pct = 0; dst_idle_pct = 0;
			end
			if ($urandom_range(4) == 0) begin
				// any register value; only part of the image is sent
				sw = $urandom_range(16383); sh = $urandom_range(65535);
				tw = $urandom_range(8191); th = $urandom_range(65535);
				count = 24;
			end else begin
				sw = $urandom_range(12, 1); sh = $urandom_range(8, 1);
				tw = $urandom_range(sw + 1, 1); th = $urandom_range(sh + 1, 1);
				count = sw * sh * $urandom_range(2, 1) + $urandom_range(3);
			end
			load_setting($urandom_range(7), $urandom_range(1), sw, sh, tw, th);
			repeat (count) send_pixel(rand_pixel());
		end

		@(negedge clk);
		src_ch.valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

### box_filter_image_downscaler.f
hw/rtl/bfid_pkg.sv
hw/rtl/bfid_if.sv
hw/rtl/bfid_div.sv
hw/rtl/bfid_lane.sv
hw/rtl/box_filter_image_downscaler.sv
hw/rtl/bfid_checker.sv
bench/tb_top.sv
